// ===== sv/rdr_pkg.sv =====
// rdr_pkg: shared types, constants and tables for the dithered raster encoder
// no dependencies

package rdr_pkg;

	localparam int DEF_MAX_WIDTH = 4096;

	// register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SCALE_MODE   = 2'd2;

	localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd384;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;
	localparam logic [1:0]  RST_SCALE_MODE   = 2'd0;

	// input item kinds
	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// luma = floor(sum / 1000) as (sum * LUMA_RECIP) >> LUMA_SHIFT, exact for sum < 2^18
	localparam logic [18:0] LUMA_RECIP = 19'd268436;
	localparam int          LUMA_SHIFT = 28;

	// result queue, power of two deep
	localparam int QDEPTH = 8;

	// header position codes
	localparam logic [2:0] POS_SCALE  = 3'd0;
	localparam logic [2:0] POS_WB_LO  = 3'd1;
	localparam logic [2:0] POS_WB_HI  = 3'd2;
	localparam logic [2:0] POS_H_LO   = 3'd3;
	localparam logic [2:0] POS_H_HI   = 3'd4;
	localparam logic [2:0] POS_DATA   = 3'd5;

	typedef struct packed {
		logic       hdr;
		logic       data;
		logic [7:0] byte_val;
		logic       last;
	} rec_t;

	// bayer 4x4 entry times 15
	function automatic logic [7:0] bayer_thr(input logic [1:0] r, input logic [1:0] c);
		logic [7:0] t;
		unique case ({r, c})
			4'h0: t = 8'd0;
			4'h1: t = 8'd120;
			4'h2: t = 8'd30;
			4'h3: t = 8'd150;
			4'h4: t = 8'd180;
			4'h5: t = 8'd60;
			4'h6: t = 8'd210;
			4'h7: t = 8'd90;
			4'h8: t = 8'd45;
			4'h9: t = 8'd165;
			4'hA: t = 8'd15;
			4'hB: t = 8'd135;
			4'hC: t = 8'd225;
			4'hD: t = 8'd105;
			4'hE: t = 8'd195;
			4'hF: t = 8'd75;
			default: t = 8'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/rgb_to_dithered_raster.sv =====
// rgb_to_dithered_raster: rgb pixels to a 1bpp ordered-dither printer raster
// depends on rdr_pkg
//
// input channel (in_valid / in_stall) carries either a gamma table write
// (kind 0) or a pixel (kind 1) in raster order. the output channel
// (out_valid / out_stall) carries bytes: five header bytes before the first
// data byte of a frame, then the packed rows, last high on the final byte.
// one input transfer per cycle is taken while the result queue has room;
// a pixel that ends a byte or opens a frame has its record pushed after the
// capture, sum and gamma-read registers; the record leaves at the queue head.
// the output gives at most one byte per cycle. the gamma table is a 256x8
// single-port ram with a registered read: a table write and a pixel lookup
// use it in the same pipeline stage, so program order is kept without
// forwarding. in_stall rises when queued records plus items in flight would
// fill the eight-entry queue; with a stalled receiver the head byte holds.
// reset clears the frame position, the queue and the registers (width 384,
// height 1, scale 0); the gamma table stays unknown until written.

module rgb_to_dithered_raster #(
	parameter int MAX_WIDTH = rdr_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  table_index,
	input  logic [7:0]  table_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int WW  = (CW > 13) ? CW : 13;
	localparam int PW  = $clog2(rdr_pkg::QDEPTH);
	localparam int NW  = $clog2(rdr_pkg::QDEPTH + 1);

	// configuration
	logic [12:0] image_width_q;
	logic [15:0] image_height_q;
	logic [1:0]  scale_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= rdr_pkg::RST_IMAGE_WIDTH;
			image_height_q <= rdr_pkg::RST_IMAGE_HEIGHT;
			scale_mode_q   <= rdr_pkg::RST_SCALE_MODE;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				rdr_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[12:0];
				rdr_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				rdr_pkg::REG_SCALE_MODE:   scale_mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0] width_ext;
	logic [CW-1:0] eff_w;
	logic [15:0]   eff_h;
	logic [15:0]   row_bytes;

	always_comb begin
		width_ext = WW'(image_width_q);
		priority if (width_ext == '0)
			eff_w = CW'(1);
		else if (width_ext > WW'(MAX_WIDTH))
			eff_w = CW'(MAX_WIDTH);
		else
			eff_w = CW'(width_ext);
		eff_h = (image_height_q == 16'd0) ? 16'd1 : image_height_q;
		row_bytes = 16'(({1'b0, eff_w} + (CW + 1)'(7)) >> 3);
	end

	// pipeline valids and queue occupancy
	logic          v_s1, v_s2, v_s3;
	logic [NW-1:0] count_q;
	logic          in_xfer;
	logic [NW+1:0] reserved;

	assign reserved = (NW + 2)'(count_q) + (NW + 2)'(v_s1) + (NW + 2)'(v_s2)
		+ (NW + 2)'(v_s3);
	assign in_stall = reserved >= (NW + 2)'(rdr_pkg::QDEPTH);
	assign in_xfer  = in_valid && !in_stall;

	// stage 1: captured transfer
	logic       kind_s1;
	logic [7:0] red_s1, green_s1, blue_s1, tidx_s1, tval_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1  <= kind;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			tidx_s1  <= table_index;
			tval_s1  <= table_value;
		end
	end

	// stage 2: weighted sum
	logic        kind_s2;
	logic [17:0] sum_s2;
	logic [7:0]  tidx_s2, tval_s2;

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		tidx_s2 <= tidx_s1;
		tval_s2 <= tval_s1;
		sum_s2  <= 18'(red_s1) * 18'd299 + 18'(green_s1) * 18'd587
			+ 18'(blue_s1) * 18'd114;
	end

	// luma by reciprocal, then gamma ram access
	logic [36:0] luma_prod;
	logic [7:0]  luma;

	assign luma_prod = 37'(sum_s2) * 37'(rdr_pkg::LUMA_RECIP);
	assign luma      = luma_prod[rdr_pkg::LUMA_SHIFT +: 8];

	logic [7:0] gamma_mem [256];
	logic       kind_s3;
	logic [7:0] gray_s3;

	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		if (v_s2 && kind_s2 == rdr_pkg::KIND_TABLE)
			gamma_mem[tidx_s2] <= tval_s2;
		else
			gray_s3 <= gamma_mem[luma];
	end

	// stage 3: dither, pack and frame position
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [7:0]    pack_q;
	logic          header_done_q;

	logic          pix_s3, dark, row_end, frame_end, emit, push;
	logic [7:0]    packed_byte;
	logic [CW-1:0] col_n;
	logic [15:0]   row_n;
	rdr_pkg::rec_t push_rec;

	always_comb begin
		pix_s3      = v_s3 && kind_s3 == rdr_pkg::KIND_PIXEL;
		dark        = gray_s3 <= rdr_pkg::bayer_thr(row_q[1:0], col_q[1:0]);
		packed_byte = pack_q | (dark ? (8'h80 >> col_q[2:0]) : 8'h00);
		col_n       = col_q + CW'(1);
		row_end     = col_n >= eff_w;
		row_n       = row_q + 16'd1;
		frame_end   = row_end && (row_n >= eff_h);
		emit        = row_end || (col_n[2:0] == 3'd0);
		push        = pix_s3 && (emit || !header_done_q);
		push_rec.hdr      = !header_done_q;
		push_rec.data     = emit;
		push_rec.byte_val = packed_byte;
		push_rec.last     = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			pack_q        <= '0;
			header_done_q <= 1'b0;
		end else if (pix_s3) begin
			pack_q        <= emit ? 8'h00 : packed_byte;
			header_done_q <= !frame_end;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? 16'd0 : row_n;
			end else begin
				col_q <= col_n;
			end
		end
	end

	// result queue and header unrolling
	rdr_pkg::rec_t q_mem [rdr_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0]    pos_q;
	rdr_pkg::rec_t head;
	logic          out_xfer, rec_done, pop;
	logic          show_hdr;

	assign head      = q_mem[rd_ptr_q];
	assign out_valid = count_q != '0;
	assign out_xfer  = out_valid && !out_stall;
	assign show_hdr  = head.hdr && (pos_q < rdr_pkg::POS_DATA);
	assign rec_done  = head.hdr ? (head.data ? (pos_q == rdr_pkg::POS_DATA)
		: (pos_q == rdr_pkg::POS_H_HI)) : 1'b1;
	assign pop       = out_xfer && rec_done;

	always_comb begin
		out_byte = head.byte_val;
		last     = head.last;
		if (show_hdr) begin
			last = 1'b0;
			unique case (pos_q)
				rdr_pkg::POS_SCALE: out_byte = 8'(scale_mode_q);
				rdr_pkg::POS_WB_LO: out_byte = row_bytes[7:0];
				rdr_pkg::POS_WB_HI: out_byte = row_bytes[15:8];
				rdr_pkg::POS_H_LO:  out_byte = eff_h[7:0];
				rdr_pkg::POS_H_HI:  out_byte = eff_h[15:8];
				default:            out_byte = head.byte_val;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			pos_q    <= rdr_pkg::POS_SCALE;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
			if (out_xfer)
				pos_q <= rec_done ? rdr_pkg::POS_SCALE : pos_q + 3'd1;
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(rdr_pkg::QDEPTH))
		else $error("result queue over capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < NW'(rdr_pkg::QDEPTH)) || pop)
		else $error("record pushed into a full queue");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_q <= rdr_pkg::POS_DATA)
			&& (head.hdr || pos_q == rdr_pkg::POS_SCALE))
		else $error("header position out of step with head record");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pix_s3 |=> col_q < $past(eff_w))
		else $error("column past effective width");

	a_frame_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_s3 && frame_end) |=> (col_q == '0) && (row_q == 16'd0) && !header_done_q)
		else $error("frame end did not restart position");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench for rgb_to_dithered_raster: feeds gamma writes and pixels, predicts the
// frame header and the packed ordered-dither raster, checks every output transfer
// depends on rdr_pkg and rgb_to_dithered_raster

module testbench;

	localparam logic [1:0]  REG_SPARE    = 2'd3;
	localparam logic [63:0] BAYER_ORDER  = 64'h5D7F_91B3_6E4C_A280;
	localparam int          SETTLE_TICKS = 12;
	localparam int          CYCLE_LIMIT  = 500000;

	typedef struct {
		logic       kind;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] idx;
		logic [7:0] val;
	} feed_item_t;

	typedef struct {
		logic [7:0] data;
		logic       is_last;
	} raster_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic [7:0]  table_index = '0;
	logic [7:0]  table_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	rgb_to_dithered_raster u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.table_index (table_index),
		.table_value (table_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last        (last)
	);

	feed_item_t   feed_q[$];
	raster_byte_t raster_q[$];
	feed_item_t   feed_cur;
	raster_byte_t want;

	// predictor state
	logic [7:0]  gamma_lut[256];
	int          col_pos;
	int          row_pos;
	logic [7:0]  pack_bits;
	logic        hdr_sent;
	logic [12:0] img_width;
	logic [15:0] img_height;
	logic [1:0]  img_scale;

	logic in_taken = 1'b0;
	int   feed_gap = 0;
	int   feed_calm = 0;
	int   stall_left = 0;
	int   stall_calm = 0;
	int   cycles = 0;
	int   mismatches = 0;
	int   bytes_checked = 0;
	int   frames_done = 0;
	int   pixels_sent = 0;
	int   gamma_writes = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int exp_val);
		$display("mismatch at byte %0d: %s got 0x%0h expected 0x%0h", bytes_checked, what,
			got, exp_val);
		mismatches++;
	endtask

	task automatic expect_byte(input logic [7:0] data, input logic is_last);
		raster_byte_t rb;
		rb.data = data;
		rb.is_last = is_last;
		raster_q.push_back(rb);
	endtask

	task automatic dither_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int w;
		int h;
		int wb;
		int luma;
		int thr;
		logic [7:0] gray;
		logic row_end;
		logic frame_end;
		w = (img_width == 0) ? 1 : (img_width > rdr_pkg::DEF_MAX_WIDTH) ?
			rdr_pkg::DEF_MAX_WIDTH : int'(img_width);
		h = (img_height == 0) ? 1 : int'(img_height);
		if (!hdr_sent) begin
			wb = (w + 7) / 8;
			expect_byte({6'd0, img_scale}, 1'b0);
			expect_byte(wb[7:0], 1'b0);
			expect_byte(wb[15:8], 1'b0);
			expect_byte(h[7:0], 1'b0);
			expect_byte(h[15:8], 1'b0);
			hdr_sent = 1'b1;
		end
		luma = (299 * r + 587 * g + 114 * b) / 1000;
		gray = gamma_lut[luma];
		thr = int'(BAYER_ORDER[(((row_pos & 3) * 4) + (col_pos & 3)) * 4 +: 4]) * 15;
		if (gray <= thr)
			pack_bits[7 - (col_pos & 7)] = 1'b1;
		col_pos++;
		row_end = (col_pos >= w);
		frame_end = 1'b0;
		if (row_end || (col_pos & 7) == 0) begin
			if (row_end) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h) begin
					row_pos = 0;
					frame_end = 1'b1;
					hdr_sent = 1'b0;
				end
			end
			expect_byte(pack_bits, frame_end);
			pack_bits = '0;
		end
	endtask

	// output check, register and input tracking on the rising edge
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (raster_q.size() == 0)
					flag_mismatch("unexpected byte", int'(out_byte), 0);
				else begin
					want = raster_q.pop_front();
					if (out_byte !== want.data)
						flag_mismatch("out_byte", int'(out_byte), int'(want.data));
					if (last !== want.is_last)
						flag_mismatch("last", int'(last), int'(want.is_last));
					bytes_checked++;
					if (want.is_last)
						frames_done++;
				end
			end
			if (cfg_write_en) begin
				case (cfg_index)
					rdr_pkg::REG_IMAGE_WIDTH: img_width = cfg_data[12:0];
					rdr_pkg::REG_IMAGE_HEIGHT: img_height = cfg_data;
					rdr_pkg::REG_SCALE_MODE: img_scale = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				if (kind == rdr_pkg::KIND_TABLE) begin
					gamma_lut[table_index] = table_value;
					gamma_writes++;
				end else begin
					dither_pixel(red, green, blue);
					pixels_sent++;
				end
			end
		end
	end

	// input transfer driver
	always @(negedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || in_taken) begin
			if (feed_gap > 0) begin
				feed_gap--;
				in_valid <= 1'b0;
			end else if (feed_q.size() != 0) begin
				feed_cur = feed_q.pop_front();
				kind <= feed_cur.kind;
				red <= feed_cur.r;
				green <= feed_cur.g;
				blue <= feed_cur.b;
				table_index <= feed_cur.idx;
				table_value <= feed_cur.val;
				in_valid <= 1'b1;
				feed_gap = next_gap(feed_calm);
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = next_gap(stall_calm);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycles,
				raster_q.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		feed_item_t it;
		it.kind = rdr_pkg::KIND_PIXEL;
		it.r = r;
		it.g = g;
		it.b = b;
		it.idx = 8'($urandom);
		it.val = 8'($urandom);
		feed_q.push_back(it);
	endtask

	task automatic push_gamma(input logic [7:0] idx, input logic [7:0] val);
		feed_item_t it;
		it.kind = rdr_pkg::KIND_TABLE;
		it.r = 8'($urandom);
		it.g = 8'($urandom);
		it.b = 8'($urandom);
		it.idx = idx;
		it.val = val;
		feed_q.push_back(it);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// sender holds off until every expected byte has been taken and the pipeline is quiet
	task automatic settle();
		int quiet;
		quiet = 0;
		while (quiet < SETTLE_TICKS) begin
			@(negedge clk);
			if (feed_q.size() != 0 || in_valid || raster_q.size() != 0)
				quiet = 0;
			else
				quiet++;
		end
	endtask

	initial begin
		int phase;
		int n;
		int pick;
		logic [15:0] wv;
		logic [15:0] hv;
		col_pos = 0;
		row_pos = 0;
		pack_bits = '0;
		hdr_sent = 1'b0;
		img_width = rdr_pkg::RST_IMAGE_WIDTH;
		img_height = rdr_pkg::RST_IMAGE_HEIGHT;
		img_scale = rdr_pkg::RST_SCALE_MODE;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// whole gamma table first, black and white pinned
		for (n = 0; n < 256; n++)
			push_gamma(n[7:0], (n == 0) ? 8'h00 : (n == 255) ? 8'hFF : 8'($urandom));

		// reset registers: 384 wide, one row
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'h00, 8'h00);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'h00, 8'h00, 8'hFF);
		push_gamma(8'd149, 8'h00);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h00, 8'h00, 8'h00);
		settle();

		// zero width and height mid-frame: every pixel closes a frame
		write_reg(rdr_pkg::REG_IMAGE_WIDTH, 16'd0);
		write_reg(rdr_pkg::REG_IMAGE_HEIGHT, 16'd0);
		write_reg(rdr_pkg::REG_SCALE_MODE, 16'd3);
		push_pixel(8'h80, 8'h40, 8'h20);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		settle();

		// oversized width and full height in the header
		write_reg(rdr_pkg::REG_IMAGE_WIDTH, 16'h1FFF);
		write_reg(rdr_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
		write_reg(rdr_pkg::REG_SCALE_MODE, 16'd1);
		for (n = 0; n < 9; n++)
			push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		settle();

		write_reg(rdr_pkg::REG_IMAGE_WIDTH, 16'd4096);
		write_reg(rdr_pkg::REG_IMAGE_HEIGHT, 16'd2);
		write_reg(rdr_pkg::REG_SCALE_MODE, 16'd2);
		push_pixel(8'h7F, 8'h7F, 8'h7F);
		push_pixel(8'h01, 8'hFE, 8'h55);
		settle();

		// shrink width below the column: row ends on the next pixel
		write_reg(rdr_pkg::REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_SPARE, 16'hFFFF);
		for (n = 0; n < 4; n++)
			push_pixel(8'($urandom), 8'($urandom), 8'($urandom));

		for (phase = 0; phase < 6; phase++) begin
			settle();
			pick = $urandom_range(0, 9);
			wv = (pick == 0) ? 16'd4096 : (pick == 1) ? 16'd0 :
				(pick == 2) ? 16'hE005 : 16'($urandom_range(1, 24));
			hv = (pick == 3) ? 16'd0 : 16'($urandom_range(1, 4));
			write_reg(rdr_pkg::REG_IMAGE_HEIGHT, hv);
			write_reg(rdr_pkg::REG_IMAGE_WIDTH, wv);
			write_reg(rdr_pkg::REG_SCALE_MODE, 16'($urandom_range(0, 3)));
			for (n = 0; n < 25; n++) begin
				if ($urandom_range(0, 9) == 0)
					push_gamma(8'($urandom), 8'($urandom));
				else
					push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			end
		end

		settle();
		repeat (20) @(negedge clk);
		$display("summary: %0d pixels and %0d gamma writes sent, %0d bytes checked",
			pixels_sent, gamma_writes, bytes_checked);
		$display("summary: %0d frames closed over several width, height and scale settings",
			frames_done);
		if (mismatches == 0 && raster_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rdr_pkg.sv
sv/rgb_to_dithered_raster.sv
tb/testbench.sv
